FILE: hw/rtl/spd_pkg.sv
`default_nettype none
package spd_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadW    = 31;
  localparam int unsigned GapW    = 36;
  localparam int unsigned MnW     = 17;
  localparam int unsigned NormW   = 34;
  localparam int unsigned SqW     = 68;
  localparam int unsigned SqSteps = 34;
  localparam int unsigned GqW     = 31;
  localparam int unsigned HqW     = 34;
  localparam int unsigned NPairs  = 6;

  localparam logic [MnW-1:0] MinNormReset = 17'd1;
  localparam logic [2:0]     AddrMinNorm  = 3'd0;

  localparam int PairI [NPairs] = '{0, 0, 0, 1, 1, 2};
  localparam int PairJ [NPairs] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic [GapW-1:0]           gap;
    logic [2:0][31:0]          g;
    logic [NPairs-1:0][31:0]   h;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sphere_pair_distance_derivs.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  two centers, two radii
// out_     output     out_valid/out_stall gap, gradient, six Hessian entries
// cfg_     APB        psel/penable       min_norm at address 0
//
// One transaction per cycle while in_stall is low.
// The pipeline runs through the 34-step square root, the 31-step gradient divider and
// the 34-step Hessian divider, one bit per stage.
// rst_n is synchronous, active low; it clears all valid bits and min_norm to 1.
// The whole pipeline moves together; a two-entry output buffer lets one more
// transaction in while a result waits, and in_stall is taken from a register.
`default_nettype none
module sphere_pair_distance_derivs import spd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [CoordW-1:0] in_center_a_x,
  input  wire logic signed [CoordW-1:0] in_center_a_y,
  input  wire logic signed [CoordW-1:0] in_center_a_z,
  input  wire logic signed [CoordW-1:0] in_center_b_x,
  input  wire logic signed [CoordW-1:0] in_center_b_y,
  input  wire logic signed [CoordW-1:0] in_center_b_z,
  input  wire logic        [RadW-1:0]   in_radius_a,
  input  wire logic        [RadW-1:0]   in_radius_b,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [GapW-1:0]        out_gap,
  output logic signed [31:0]            out_grad_x,
  output logic signed [31:0]            out_grad_y,
  output logic signed [31:0]            out_grad_z,
  output logic signed [31:0]            out_hess_xx,
  output logic signed [31:0]            out_hess_xy,
  output logic signed [31:0]            out_hess_xz,
  output logic signed [31:0]            out_hess_yy,
  output logic signed [31:0]            out_hess_yz,
  output logic signed [31:0]            out_hess_zz,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef struct packed {
    logic                 v;
    logic [2:0][32:0]     d;
    logic [31:0]          rsum;
  } s1_t;

  typedef struct packed {
    logic                 v;
    logic [2:0]           sgn;
    logic [2:0][32:0]     m;
    logic [2:0][65:0]     sq;
    logic [31:0]          rsum;
  } s2_t;

  typedef struct packed {
    logic                 v;
    logic [SqW-1:0]       op;
    logic [SqW-1:0]       res;
    logic [2:0]           sgn;
    logic [2:0][32:0]     m;
    logic [31:0]          rsum;
  } sq_t;

  typedef struct packed {
    logic                 v;
    logic [NormW-1:0]     nc;
    logic [GapW-1:0]      gap;
    logic [2:0]           sgn;
    logic [2:0][NormW-1:0] rem;
    logic [2:0][GqW-1:0]  lo;
    logic [2:0][GqW-1:0]  q;
  } gd_t;

  typedef struct packed {
    logic                    v;
    logic [NormW-1:0]        nc;
    logic [GapW-1:0]         gap;
    logic [2:0][31:0]        g;
    logic [2:0]              ng;
    logic [NPairs-1:0][61:0] pm;
  } pr_t;

  typedef struct packed {
    logic                       v;
    logic [NormW-1:0]           nc;
    logic [GapW-1:0]            gap;
    logic [2:0][31:0]           g;
    logic [NPairs-1:0]          hn;
    logic [NPairs-1:0][NormW-1:0] rem;
    logic [NPairs-1:0][HqW-1:0] lo;
    logic [NPairs-1:0][HqW-1:0] q;
  } hd_t;

  logic [MnW-1:0] min_norm_r;
  logic           adv;
  logic           skid_v_r, out_v_r;
  res_t           skid_r, out_r, res_nxt;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  sq_t sq_r [SqSteps+1];
  sq_t sq0_nxt;
  gd_t gd_r [GqW+1];
  gd_t gd0_nxt;
  pr_t p_r, p_nxt;
  hd_t hd_r [HqW+1];
  hd_t hd0_nxt;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == AddrMinNorm) ? {{(32-MnW){1'b0}}, min_norm_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_norm_r <= MinNormReset;
    end else if (psel && penable && pwrite && paddr == AddrMinNorm) begin
      min_norm_r <= pwdata[MnW-1:0];
    end
  end

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage 1: difference vector, radius sum
  always_comb begin
    s1_nxt.v    = in_valid;
    s1_nxt.d[0] = {in_center_a_x[31], in_center_a_x} - {in_center_b_x[31], in_center_b_x};
    s1_nxt.d[1] = {in_center_a_y[31], in_center_a_y} - {in_center_b_y[31], in_center_b_y};
    s1_nxt.d[2] = {in_center_a_z[31], in_center_a_z} - {in_center_b_z[31], in_center_b_z};
    s1_nxt.rsum = {1'b0, in_radius_a} + {1'b0, in_radius_b};
  end

  // stage 2: magnitudes and squares
  always_comb begin
    s2_nxt.v    = s1_r.v;
    s2_nxt.rsum = s1_r.rsum;
    for (int i = 0; i < 3; i++) begin
      s2_nxt.sgn[i] = s1_r.d[i][32];
      s2_nxt.m[i]   = s1_r.d[i][32] ? (33'd0 - s1_r.d[i]) : s1_r.d[i];
      s2_nxt.sq[i]  = {33'd0, s2_nxt.m[i]} * {33'd0, s2_nxt.m[i]};
    end
  end

  // stage 3: sum of squares
  always_comb begin
    sq0_nxt.v    = s2_r.v;
    sq0_nxt.op   = {2'b00, s2_r.sq[0]} + {2'b00, s2_r.sq[1]} + {2'b00, s2_r.sq[2]};
    sq0_nxt.res  = '0;
    sq0_nxt.sgn  = s2_r.sgn;
    sq0_nxt.m    = s2_r.m;
    sq0_nxt.rsum = s2_r.rsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r     <= '0;
      s2_r     <= '0;
      sq_r[0]  <= '0;
    end else if (adv) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      sq_r[0]  <= sq0_nxt;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam logic [SqW-1:0] One = {{(SqW-1){1'b0}}, 1'b1} << (2*(SqSteps-1-k));
    sq_t            nx;
    logic [SqW-1:0] tr;
    always_comb begin
      nx = sq_r[k];
      tr = sq_r[k].res + One;
      if (sq_r[k].op >= tr) begin
        nx.op  = sq_r[k].op - tr;
        nx.res = (sq_r[k].res >> 1) + One;
      end else begin
        nx.res = sq_r[k].res >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k+1] <= '0;
      end else if (adv) begin
        sq_r[k+1] <= nx;
      end
    end
  end

  // clamp, gap, gradient numerators
  logic [NormW-1:0] n_w, mn_w, nc_w;
  logic [63:0]      gnum [3];
  always_comb begin
    n_w  = sq_r[SqSteps].res[NormW-1:0];
    mn_w = (min_norm_r == '0) ? NormW'(1) : {{(NormW-MnW){1'b0}}, min_norm_r};
    nc_w = (n_w > mn_w) ? n_w : mn_w;
    gd0_nxt.v   = sq_r[SqSteps].v;
    gd0_nxt.nc  = nc_w;
    gd0_nxt.gap = {2'b00, n_w} - {4'd0, sq_r[SqSteps].rsum};
    gd0_nxt.sgn = sq_r[SqSteps].sgn;
    for (int i = 0; i < 3; i++) begin
      gnum[i] = {1'b0, sq_r[SqSteps].m[i], 30'd0} + {31'd0, nc_w[NormW-1:1]};
      gd0_nxt.rem[i] = {1'b0, gnum[i][63:31]};
      gd0_nxt.lo[i]  = gnum[i][30:0];
      gd0_nxt.q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gd_r[0] <= '0;
    end else if (adv) begin
      gd_r[0] <= gd0_nxt;
    end
  end

  // gradient dividers, one quotient bit per stage
  for (genvar k = 0; k < GqW; k++) begin : g_gdiv
    gd_t          nx;
    logic [NormW:0] t [3];
    always_comb begin
      nx = gd_r[k];
      for (int i = 0; i < 3; i++) begin
        t[i]     = {gd_r[k].rem[i], gd_r[k].lo[i][GqW-1]};
        nx.lo[i] = gd_r[k].lo[i] << 1;
        if (t[i] >= {1'b0, gd_r[k].nc}) begin
          nx.rem[i] = NormW'(t[i] - {1'b0, gd_r[k].nc});
          nx.q[i]   = {gd_r[k].q[i][GqW-2:0], 1'b1};
        end else begin
          nx.rem[i] = t[i][NormW-1:0];
          nx.q[i]   = {gd_r[k].q[i][GqW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        gd_r[k+1] <= '0;
      end else if (adv) begin
        gd_r[k+1] <= nx;
      end
    end
  end

  // gradient sign and clamp, pair products
  localparam logic [GqW-1:0] OneQ30 = GqW'(1) << 30;
  logic [GqW-1:0] qs [3];
  always_comb begin
    p_nxt.v   = gd_r[GqW].v;
    p_nxt.nc  = gd_r[GqW].nc;
    p_nxt.gap = gd_r[GqW].gap;
    for (int i = 0; i < 3; i++) begin
      qs[i]       = (gd_r[GqW].q[i] > OneQ30) ? OneQ30 : gd_r[GqW].q[i];
      p_nxt.g[i]  = gd_r[GqW].sgn[i] ? (32'd0 - {1'b0, qs[i]}) : {1'b0, qs[i]};
      p_nxt.ng[i] = gd_r[GqW].sgn[i] && (qs[i] != '0);
    end
    for (int k = 0; k < NPairs; k++) begin
      p_nxt.pm[k] = {31'd0, qs[PairI[k]]} * {31'd0, qs[PairJ[k]]};
    end
  end

  // Hessian numerators, rounding bias and scale folded in
  localparam logic [60:0] One60 = 61'd1 << 60;
  logic [60:0] hmag [NPairs];
  logic [61:0] hx   [NPairs];
  always_comb begin
    hd0_nxt.v   = p_r.v;
    hd0_nxt.nc  = p_r.nc;
    hd0_nxt.gap = p_r.gap;
    hd0_nxt.g   = p_r.g;
    for (int k = 0; k < NPairs; k++) begin
      if (PairI[k] == PairJ[k]) begin
        hmag[k]       = One60 - p_r.pm[k][60:0];
        hd0_nxt.hn[k] = 1'b0;
      end else begin
        hmag[k]       = p_r.pm[k][60:0];
        hd0_nxt.hn[k] = !(p_r.ng[PairI[k]] ^ p_r.ng[PairJ[k]]) && (p_r.pm[k] != '0);
      end
      hx[k]          = {1'b0, hmag[k]} + {1'b0, p_r.nc, 27'd0};
      hd0_nxt.lo[k]  = hx[k][61:28];
      hd0_nxt.rem[k] = '0;
      hd0_nxt.q[k]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r     <= '0;
      hd_r[0] <= '0;
    end else if (adv) begin
      p_r     <= p_nxt;
      hd_r[0] <= hd0_nxt;
    end
  end

  // Hessian dividers
  for (genvar k = 0; k < HqW; k++) begin : g_hdiv
    hd_t            nx;
    logic [NormW:0] t [NPairs];
    always_comb begin
      nx = hd_r[k];
      for (int i = 0; i < NPairs; i++) begin
        t[i]     = {hd_r[k].rem[i], hd_r[k].lo[i][HqW-1]};
        nx.lo[i] = hd_r[k].lo[i] << 1;
        if (t[i] >= {1'b0, hd_r[k].nc}) begin
          nx.rem[i] = NormW'(t[i] - {1'b0, hd_r[k].nc});
          nx.q[i]   = {hd_r[k].q[i][HqW-2:0], 1'b1};
        end else begin
          nx.rem[i] = t[i][NormW-1:0];
          nx.q[i]   = {hd_r[k].q[i][HqW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hd_r[k+1] <= '0;
      end else if (adv) begin
        hd_r[k+1] <= nx;
      end
    end
  end

  // final saturation
  localparam logic [HqW-1:0] PosLim = HqW'(32'h7FFF_FFFF);
  localparam logic [HqW-1:0] NegLim = HqW'(33'h1_0000_0000) >> 1;
  logic [HqW-1:0] hq [NPairs];
  always_comb begin
    res_nxt.gap = hd_r[HqW].gap;
    res_nxt.g   = hd_r[HqW].g;
    for (int k = 0; k < NPairs; k++) begin
      hq[k] = hd_r[HqW].q[k];
      if (hd_r[HqW].hn[k]) begin
        res_nxt.h[k] = (hq[k] > NegLim) ? 32'h8000_0000 : (32'd0 - hq[k][31:0]);
      end else begin
        res_nxt.h[k] = (hq[k] > PosLim) ? 32'h7FFF_FFFF : hq[k][31:0];
      end
    end
  end

  // output register and skid entry
  logic push;
  assign push = adv && hd_r[HqW].v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= push;
      end else begin
        out_v_r  <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        if (push) skid_r <= res_nxt;
      end else if (push) begin
        out_r <= res_nxt;
      end
    end else if (push) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid   = out_v_r;
  assign out_gap     = out_r.gap;
  assign out_grad_x  = out_r.g[0];
  assign out_grad_y  = out_r.g[1];
  assign out_grad_z  = out_r.g[2];
  assign out_hess_xx = out_r.h[0];
  assign out_hess_xy = out_r.h[1];
  assign out_hess_xz = out_r.h[2];
  assign out_hess_yy = out_r.h[3];
  assign out_hess_yz = out_r.h[4];
  assign out_hess_zz = out_r.h[5];

endmodule
`default_nettype wire

FILE: hw/rtl/spd_checker.sv
`default_nettype none
module spd_checker import spd_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [31:0] out_grad_x,
  input wire logic signed [31:0] out_hess_xx,
  input wire logic signed [31:0] out_hess_yy,
  input wire logic signed [31:0] out_hess_zz
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  a_grad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_grad_x <= 32'sh4000_0000 && out_grad_x >= -32'sh4000_0000))
    else $error("gradient beyond unit");

  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hess_xx >= 0 && out_hess_yy >= 0 && out_hess_zz >= 0))
    else $error("negative Hessian diagonal");

endmodule

bind sphere_pair_distance_derivs spd_checker u_spd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_grad_x (out_grad_x),
  .out_hess_xx(out_hess_xx),
  .out_hess_yy(out_hess_yy),
  .out_hess_zz(out_hess_zz)
);
`default_nettype wire

FILE: test/sphere_pair_distance_derivs_tb.sv
`default_nettype none
module sphere_pair_distance_derivs_tb;
  import spd_pkg::*;

  localparam int HoldCycles = 300;
  localparam int Settle = 130;
  localparam int IdleLimit = 4000;
  localparam int PerSetting = 134;

  typedef struct packed {
    logic [2:0][31:0] ca;
    logic [2:0][31:0] cb;
    logic [RadW-1:0]  ra;
    logic [RadW-1:0]  rb;
  } pair_t;

  typedef struct packed {
    pair_t p;
    logic  typed;
    res_t  r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pair_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [GapW-1:0] out_gap;
  logic signed [31:0] out_grad_x, out_grad_y, out_grad_z;
  logic signed [31:0] out_hess_xx, out_hess_xy, out_hess_xz;
  logic signed [31:0] out_hess_yy, out_hess_yz, out_hess_zz;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  sphere_pair_distance_derivs dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_center_a_x(drv.ca[0]), .in_center_a_y(drv.ca[1]), .in_center_a_z(drv.ca[2]),
    .in_center_b_x(drv.cb[0]), .in_center_b_y(drv.cb[1]), .in_center_b_z(drv.cb[2]),
    .in_radius_a(drv.ra), .in_radius_b(drv.rb),
    .out_valid, .out_stall, .out_gap,
    .out_grad_x, .out_grad_y, .out_grad_z,
    .out_hess_xx, .out_hess_xy, .out_hess_xz,
    .out_hess_yy, .out_hess_yz, .out_hess_zz,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  logic [MnW-1:0] min_norm_q = MinNormReset;
  res_t derivs_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int send_idle = 0;
  int rcv_idle = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic longint div_round(longint num, longint den);
    longint m, q;
    m = num < 0 ? -num : num;
    q = (m + (den >>> 1)) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic res_t pair_derivs(pair_t p);
    longint v[3];
    longint g[3];
    logic [32:0] m;
    logic [67:0] ssq, cc;
    logic [33:0] n, c;
    longint nc, den, num, gap;
    res_t r;
    int k;
    ssq = '0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(p.ca[i])) - longint'($signed(p.cb[i]));
      m = 33'(v[i] < 0 ? -v[i] : v[i]);
      ssq += {35'b0, m} * {35'b0, m};
    end
    n = '0;
    for (int b = 33; b >= 0; b--) begin
      c = n | (34'd1 << b);
      cc = {34'b0, c} * {34'b0, c};
      if (cc <= ssq) n = c;
    end
    nc = (min_norm_q == 0) ? 1 : longint'(min_norm_q);
    if (longint'(n) > nc) nc = longint'(n);
    gap = longint'(n) - longint'(p.ra) - longint'(p.rb);
    gap = clamp(gap, -(64'sd1 <<< 35), (64'sd1 <<< 35) - 1);
    r.gap = gap[GapW-1:0];
    for (int i = 0; i < 3; i++) begin
      g[i] = clamp(div_round(v[i] <<< 30, nc), -(64'sd1 <<< 30), 64'sd1 <<< 30);
      r.g[i] = g[i][31:0];
    end
    den = nc <<< 28;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = i; j < 3; j++) begin
        num = (i == j ? (64'sd1 <<< 60) : 0) - g[i] * g[j];
        num = clamp(div_round(num, den), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        r.h[k] = num[31:0];
        k++;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      p.ca[i] = $urandom();
      case (mode)
        0, 1, 2, 3: p.cb[i] = $urandom();
        4, 5, 6: p.cb[i] = p.ca[i] + ($signed($urandom()) >>> $urandom_range(31));
        7: p.cb[i] = p.ca[i];
        8: begin
          p.ca[i] = rand_coord();
          p.cb[i] = rand_coord();
        end
        default: p.cb[i] = p.ca[i] + ($signed($urandom()) >>> (14 + $urandom_range(17)));
      endcase
    end
    p.ra = RadW'($urandom() >> $urandom_range(30));
    p.rb = RadW'($urandom() >> $urandom_range(30));
    if ($urandom_range(15) == 0) p.ra = '1;
    if ($urandom_range(15) == 0) p.rb = '1;
    return p;
  endfunction

  task automatic send(pair_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drv <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    derivs_q.push_back(pair_derivs(p));
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (derivs_q.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_min_norm(logic [MnW-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrMinNorm;
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    min_norm_q = val;
  endtask

  task automatic check_field(string name, logic [GapW-1:0] e, logic [GapW-1:0] a);
    if (e !== a) begin
      $display("%0t: mismatch %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (derivs_q.size() == 0) begin
        $display("%0t: unexpected transaction on output", $time);
        errors++;
      end else begin
        e = derivs_q.pop_front();
        check_field("gap", e.gap, out_gap);
        check_field("grad_x", 36'(e.g[0]), 36'($unsigned(out_grad_x)));
        check_field("grad_y", 36'(e.g[1]), 36'($unsigned(out_grad_y)));
        check_field("grad_z", 36'(e.g[2]), 36'($unsigned(out_grad_z)));
        check_field("hess_xx", 36'(e.h[0]), 36'($unsigned(out_hess_xx)));
        check_field("hess_xy", 36'(e.h[1]), 36'($unsigned(out_hess_xy)));
        check_field("hess_xz", 36'(e.h[2]), 36'($unsigned(out_hess_xz)));
        check_field("hess_yy", 36'(e.h[3]), 36'($unsigned(out_hess_yy)));
        check_field("hess_yz", 36'(e.h[4]), 36'($unsigned(out_hess_yz)));
        check_field("hess_zz", 36'(e.h[5]), 36'($unsigned(out_hess_zz)));
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  localparam logic [31:0] MaxC = 32'h7FFF_FFFF;
  localparam logic [31:0] MinC = 32'h8000_0000;
  localparam logic [RadW-1:0] MaxR = '1;
  localparam logic [5:0][31:0] CoincH = {32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                                          32'h0, 32'h0, 32'h7FFF_FFFF};

  dir_row_t dir_tab[$];
  logic [MnW-1:0] settings[6];

  initial begin
    res_t r;
    pair_t p;
    // coincident centers give a zero gradient and a saturated diagonal at min_norm 1
    dir_tab.push_back('{p: '{ca: '0, cb: '0, ra: '0, rb: '0}, typed: 1'b1,
                        r: '{gap: '0, g: '0, h: CoincH}});
    dir_tab.push_back('{p: '{ca: {MaxC, MaxC, MaxC}, cb: {MaxC, MaxC, MaxC}, ra: MaxR, rb: MaxR},
                        typed: 1'b1, r: '{gap: -36'sd4294967294, g: '0, h: CoincH}});
    dir_tab.push_back('{p: '{ca: {MinC, MinC, MinC}, cb: {MinC, MinC, MinC}, ra: MaxR, rb: '0},
                        typed: 1'b1, r: '{gap: -36'sd2147483647, g: '0, h: CoincH}});
    dir_tab.push_back('{p: '{ca: {32'h0, 32'h0, MaxC}, cb: {32'h0, 32'h0, MinC}, ra: '0, rb: '0},
                        typed: 1'b0, r: '0});
    dir_tab.push_back('{p: '{ca: {32'h0, 32'h0, MinC}, cb: {32'h0, 32'h0, MaxC}, ra: MaxR, rb: MaxR},
                        typed: 1'b0, r: '0});
    dir_tab.push_back('{p: '{ca: {32'h0, MaxC, 32'h0}, cb: {32'h0, MinC, 32'h0}, ra: 31'd5, rb: '0},
                        typed: 1'b0, r: '0});
    dir_tab.push_back('{p: '{ca: {MinC, 32'h0, 32'h0}, cb: {MaxC, 32'h0, 32'h0}, ra: '0, rb: 31'd9},
                        typed: 1'b0, r: '0});
    dir_tab.push_back('{p: '{ca: {MaxC, MinC, MaxC}, cb: {MinC, MaxC, MinC}, ra: MaxR, rb: MaxR},
                        typed: 1'b0, r: '0});
    dir_tab.push_back('{p: '{ca: {32'h0, 32'h0, 32'h1}, cb: '0, ra: '0, rb: '0},
                        typed: 1'b0, r: '0});
    dir_tab.push_back('{p: '{ca: {32'h0, 32'h4, 32'h3}, cb: '0, ra: 31'd1, rb: 31'd1},
                        typed: 1'b0, r: '0});
    dir_tab.push_back('{p: '{ca: {32'h0, 32'hFFFF_FFFF, 32'h0001_0000}, cb: {32'h1, 32'h0, 32'h0},
                        ra: 31'h0001_0000, rb: 31'h0000_8000}, typed: 1'b0, r: '0});
    dir_tab.push_back('{p: '{ca: {32'h1234_5678, 32'hDEAD_BEEF, 32'h5555_AAAA},
                        cb: {32'hAAAA_5555, 32'h0F0F_F0F0, 32'hCAFE_0001},
                        ra: 31'h2AAA_AAAA, rb: 31'h5555_5555}, typed: 1'b0, r: '0});

    // zero acts as one; the rest span the register range
    settings = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd300, 17'($urandom_range(1, 65536))};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 20;
    rcv_idle = 46;
    foreach (dir_tab[i]) begin
      send(dir_tab[i].p);
      if (dir_tab[i].typed) begin
        r = derivs_q.pop_back();
        if (r !== dir_tab[i].r) begin
          $display("%0t: table row %0d disagrees with model: expected %h model %h",
                   $time, i, dir_tab[i].r, r);
          errors++;
        end
        derivs_q.push_back(dir_tab[i].r);
      end
    end
    drain();

    for (int s = 0; s < 6; s++) begin
      write_min_norm(settings[s]);
      if (s == 2 || s == 3) begin
        send_idle = 46;
        rcv_idle = 20;
      end else if (s >= 4) begin
        send_idle = 0;
        rcv_idle = 0;
      end
      if (s == 4) hold_reqs++;
      for (int i = 0; i < PerSetting; i++) begin
        p = rand_pair();
        send(p);
      end
      drain();
    end

    $display("%0d pair transactions sent, %0d results checked", n_sent, n_checked);
    $display("covered: field extremes, coincident centers, six min_norm settings, long hold");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
